// File: rtl/core/nlp_pkg.sv
// ----------------------------------------------------------------------------
// nlp_pkg
// Shared types and codes of the integer literal parser.
// ----------------------------------------------------------------------------
package nlp_pkg;

    // character codes
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_UC_A   = 8'h41;
    localparam logic [7:0] CH_UC_F   = 8'h46;
    localparam logic [7:0] CH_LC_A   = 8'h61;
    localparam logic [7:0] CH_LC_F   = 8'h66;
    localparam logic [7:0] CH_APOS   = 8'h27;
    localparam logic [7:0] CH_UC_X   = 8'h58;
    localparam logic [7:0] CH_LC_X   = 8'h78;
    localparam logic [7:0] CH_UC_B   = 8'h42;
    localparam logic [7:0] CH_LC_B   = 8'h62;

    // radix codes
    localparam logic [1:0] RDX_DEC = 2'd0;
    localparam logic [1:0] RDX_OCT = 2'd1;
    localparam logic [1:0] RDX_HEX = 2'd2;
    localparam logic [1:0] RDX_BIN = 2'd3;

    // error codes
    localparam logic [1:0] ERR_NONE      = 2'd0;
    localparam logic [1:0] ERR_SEP       = 2'd1;
    localparam logic [1:0] ERR_NO_DIGITS = 2'd2;
    localparam logic [1:0] ERR_TOO_WIDE  = 2'd3;

    localparam int CNT_W = 6;
    localparam int NB_W  = 9;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_ZERO,
        PH_PREFIX,
        PH_MARK,
        PH_DIGITS,
        PH_SEP
    } t_phase;

    // one classified character
    typedef struct packed {
        logic       begin_req;
        logic       at_end;
        logic       is_dec;
        logic       is_zero;
        logic       is_hex;
        logic [3:0] dval;
        logic       is_apos;
        logic       is_x;
        logic       is_b;
    } t_char_info;

endpackage

// File: rtl/core/nlp_queue.sv
// ----------------------------------------------------------------------------
// nlp_queue
// Small first-word-fall-through queue with registered storage.
// ----------------------------------------------------------------------------
module nlp_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int            AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr_ptr;
    logic [AW-1:0]    r_rd_ptr;
    logic [AW:0]      r_count;
    logic             wr_en;
    logic             rd_en;

    assign o_full  = (r_count == (AW+1)'(DEPTH));
    assign o_empty = (r_count == '0);
    assign wr_en   = i_push && !o_full;
    assign rd_en   = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    // pointers wrap at the last entry, so any depth works
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (wr_en) begin
                r_wr_ptr <= (r_wr_ptr == LAST) ? '0 : r_wr_ptr + AW'(1);
            end
            if (rd_en) begin
                r_rd_ptr <= (r_rd_ptr == LAST) ? '0 : r_rd_ptr + AW'(1);
            end
            case ({wr_en, rd_en})
                2'b10:   r_count <= r_count + (AW+1)'(1);
                2'b01:   r_count <= r_count - (AW+1)'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

// File: rtl/core/nlp_front.sv
// ----------------------------------------------------------------------------
// nlp_front
// Accepts characters, classifies them and queues them for the sequencer.
// ----------------------------------------------------------------------------
module nlp_front
    import nlp_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    output logic       o_full,
    input  logic [7:0] i_ch,
    input  logic       i_begin_req,
    input  logic       i_at_end,
    input  logic       i_pop,
    output logic       o_empty,
    output t_char_info o_info
);

    t_char_info                   info;
    logic                         is_uc;
    logic                         is_lc;
    logic [$bits(t_char_info)-1:0] q_data;

    always_comb begin
        is_uc          = (i_ch >= CH_UC_A) && (i_ch <= CH_UC_F);
        is_lc          = (i_ch >= CH_LC_A) && (i_ch <= CH_LC_F);
        info.begin_req = i_begin_req;
        info.at_end    = i_at_end;
        info.is_dec    = (i_ch >= CH_ZERO) && (i_ch <= CH_NINE);
        info.is_zero   = (i_ch == CH_ZERO);
        info.is_hex    = info.is_dec || is_uc || is_lc;
        // letters a..f sit at codes ending in 1..6
        info.dval      = info.is_dec ? i_ch[3:0] : i_ch[3:0] + 4'd9;
        info.is_apos   = (i_ch == CH_APOS);
        info.is_x      = (i_ch == CH_UC_X) || (i_ch == CH_LC_X);
        info.is_b      = (i_ch == CH_UC_B) || (i_ch == CH_LC_B);
    end

    nlp_queue #(
        .WIDTH ($bits(t_char_info)),
        .DEPTH (DEPTH)
    ) u_in_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push),
        .i_data  (info),
        .o_full  (o_full),
        .i_pop   (i_pop),
        .o_data  (q_data),
        .o_empty (o_empty)
    );

    assign o_info = t_char_info'(q_data);

endmodule

// File: rtl/core/nlp_back.sv
// ----------------------------------------------------------------------------
// nlp_back
// Literal sequencer: prefix, separator and alignment handling, accumulator
// and a result register with the alignment shift behind it.
// ----------------------------------------------------------------------------
module nlp_back
    import nlp_pkg::*;
#(
    parameter int WORD_BITS = 48
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_empty,
    input  t_char_info           i_info,
    output logic                 o_in_pop,
    input  logic                 i_out_full,
    output logic                 o_em_valid,
    output logic [WORD_BITS-1:0] o_em_value,
    output logic [1:0]           o_em_err,
    output logic [1:0]           o_em_radix
);

    localparam int SH_W = $clog2(WORD_BITS);

    t_phase               r_phase;
    t_phase               n_phase;
    logic [WORD_BITS-1:0] r_acc;
    logic [WORD_BITS-1:0] n_acc;
    logic [CNT_W-1:0]     r_count;
    logic [CNT_W-1:0]     n_count;
    logic [1:0]           r_radix;
    logic [1:0]           n_radix;
    logic                 r_aligned;
    logic                 n_aligned;

    logic                 r_em_valid;
    logic [WORD_BITS-1:0] r_em_value;
    logic [SH_W-1:0]      r_em_shamt;
    logic [1:0]           r_em_err;
    logic [1:0]           r_em_radix;

    logic                 step;
    logic                 em_push;
    logic                 digit_ok;
    logic                 start_ok;
    logic [2:0]           bits;
    logic [NB_W-1:0]      nbits;
    logic [1:0]           fin_err;
    logic [SH_W-1:0]      fin_shamt;
    logic [WORD_BITS-1:0] acc_take;
    logic [CNT_W-1:0]     cnt_take;

    logic                 em_now;
    logic [1:0]           em_err;
    logic [SH_W-1:0]      em_shamt;
    logic                 clear;
    logic                 restart;

    assign em_push  = r_em_valid && !i_out_full;
    assign step     = !i_in_empty && !(r_em_valid && i_out_full);
    assign o_in_pop = step;
    assign start_ok = !i_info.at_end && i_info.begin_req && i_info.is_dec;

    always_comb begin
        case (r_radix)
            RDX_DEC: digit_ok = i_info.is_dec;
            RDX_OCT: digit_ok = i_info.is_dec && (i_info.dval <= 4'd7);
            RDX_BIN: digit_ok = i_info.is_dec && (i_info.dval <= 4'd1);
            default: digit_ok = i_info.is_hex;
        endcase
    end

    // one shift-add per digit
    always_comb begin
        case (r_radix)
            RDX_DEC: acc_take = (r_acc << 3) + (r_acc << 1) + WORD_BITS'(i_info.dval);
            RDX_OCT: acc_take = {r_acc[WORD_BITS-4:0], i_info.dval[2:0]};
            RDX_HEX: acc_take = {r_acc[WORD_BITS-5:0], i_info.dval};
            default: acc_take = {r_acc[WORD_BITS-2:0], i_info.dval[0]};
        endcase
        cnt_take = (r_count == '1) ? r_count : r_count + CNT_W'(1);
    end

    always_comb begin
        case (r_radix)
            RDX_OCT: bits = 3'd3;
            RDX_HEX: bits = 3'd4;
            default: bits = 3'd1;
        endcase
        nbits = NB_W'(r_count) * NB_W'(bits);
        if (!r_aligned) begin
            fin_err = ERR_NONE;
        end else if (r_count == '0) begin
            fin_err = ERR_NO_DIGITS;
        end else if (nbits > NB_W'(WORD_BITS)) begin
            fin_err = ERR_TOO_WIDE;
        end else begin
            fin_err = ERR_NONE;
        end
        if (r_aligned && (fin_err == ERR_NONE)) begin
            fin_shamt = SH_W'(NB_W'(WORD_BITS) - nbits);
        end else begin
            fin_shamt = '0;
        end
    end

    // next phase
    always_comb begin
        n_phase = r_phase;
        unique case (r_phase) inside
            PH_IDLE: begin
                if (start_ok) begin
                    n_phase = i_info.is_zero ? PH_ZERO : PH_DIGITS;
                end
            end
            PH_SEP, PH_MARK: begin
                n_phase = (digit_ok && !i_info.at_end) ? PH_DIGITS : PH_IDLE;
            end
            PH_ZERO, PH_PREFIX, PH_DIGITS: begin
                if (i_info.at_end) begin
                    n_phase = PH_IDLE;
                end else if (r_phase == PH_ZERO && (i_info.is_x || i_info.is_b)) begin
                    n_phase = PH_PREFIX;
                end else if (r_phase != PH_DIGITS && i_info.is_apos) begin
                    n_phase = PH_MARK;
                end else if (r_phase == PH_DIGITS && i_info.is_apos) begin
                    n_phase = PH_SEP;
                end else if (digit_ok) begin
                    n_phase = PH_DIGITS;
                end else if (fin_err == ERR_NONE && start_ok) begin
                    // terminator opens the next literal
                    n_phase = i_info.is_zero ? PH_ZERO : PH_DIGITS;
                end else begin
                    n_phase = PH_IDLE;
                end
            end
            default: n_phase = PH_IDLE;
        endcase
    end

    // datapath and result
    always_comb begin
        n_acc     = r_acc;
        n_count   = r_count;
        n_radix   = r_radix;
        n_aligned = r_aligned;
        em_now    = 1'b0;
        em_err    = ERR_NONE;
        em_shamt  = '0;
        clear     = 1'b0;
        restart   = 1'b0;
        unique case (r_phase) inside
            PH_IDLE: begin
                restart = start_ok;
            end
            PH_SEP, PH_MARK: begin
                if (digit_ok && !i_info.at_end) begin
                    n_acc   = acc_take;
                    n_count = cnt_take;
                end else begin
                    em_now = 1'b1;
                    em_err = (r_phase == PH_MARK && (!i_info.is_apos || i_info.at_end))
                           ? ERR_NO_DIGITS : ERR_SEP;
                    clear  = 1'b1;
                end
            end
            PH_ZERO, PH_PREFIX, PH_DIGITS: begin
                if (i_info.at_end) begin
                    em_now   = 1'b1;
                    em_err   = fin_err;
                    em_shamt = fin_shamt;
                    clear    = 1'b1;
                end else if (r_phase == PH_ZERO && i_info.is_x) begin
                    n_radix = RDX_HEX;
                end else if (r_phase == PH_ZERO && i_info.is_b) begin
                    n_radix = RDX_BIN;
                end else if (r_phase != PH_DIGITS && i_info.is_apos) begin
                    n_aligned = 1'b1;
                end else if (r_phase == PH_DIGITS && i_info.is_apos) begin
                    n_aligned = r_aligned;
                end else if (digit_ok) begin
                    n_acc   = acc_take;
                    n_count = cnt_take;
                end else begin
                    em_now   = 1'b1;
                    em_err   = fin_err;
                    em_shamt = fin_shamt;
                    clear    = 1'b1;
                    restart  = (fin_err == ERR_NONE) && start_ok;
                end
            end
            default: clear = 1'b1;
        endcase
        if (clear) begin
            n_acc     = '0;
            n_count   = '0;
            n_aligned = 1'b0;
        end
        if (restart) begin
            n_aligned = 1'b0;
            if (i_info.is_zero) begin
                n_radix = RDX_OCT;
                n_acc   = '0;
                n_count = '0;
            end else begin
                n_radix = RDX_DEC;
                n_acc   = WORD_BITS'(i_info.dval);
                n_count = CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_acc      <= '0;
            r_count    <= '0;
            r_radix    <= RDX_DEC;
            r_aligned  <= 1'b0;
            r_em_valid <= 1'b0;
        end else begin
            if (step) begin
                r_phase    <= n_phase;
                r_acc      <= n_acc;
                r_count    <= n_count;
                r_radix    <= n_radix;
                r_aligned  <= n_aligned;
                r_em_valid <= em_now;
            end else if (em_push) begin
                r_em_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && em_now) begin
            r_em_value <= (em_err == ERR_NONE) ? r_acc : '0;
            r_em_shamt <= em_shamt;
            r_em_err   <= em_err;
            r_em_radix <= r_radix;
        end
    end

    // left-aligned literals are packed against the top here
    assign o_em_valid = em_push;
    assign o_em_value = r_em_value << r_em_shamt;
    assign o_em_err   = r_em_err;
    assign o_em_radix = r_em_radix;

endmodule

// File: rtl/core/numeric_literal_parser_top.sv
// ----------------------------------------------------------------------------
// numeric_literal_parser_top
// Integer literal parser: characters in, one value per literal out.
// ----------------------------------------------------------------------------
// Input channel: one character per beat (i_ch, i_begin_req, i_at_end),
//   taken when push is high and full is low.
// Result channel: o_value, o_error_code, o_radix show the oldest result
//   while empty is low; pop with empty low takes it.
// A literal starts on a digit with i_begin_req set; its result comes out
// on the character that ends it (or on i_at_end), and a clean terminator
// may open the next literal in the same beat.
// Throughput: one character per cycle while the output queue has room.
// Path: a result passes the input queue, the sequencer step and the result
//   register, in that order, before it shows in the output queue.
// Reset (synchronous, i_rst_n low) empties both queues and returns the
//   sequencer to idle; no pass over storage is needed.
// When the receiver stalls, results wait in the output queue, the sequencer
//   holds, characters collect in the input queue, and full rises once
//   IN_DEPTH characters are waiting.
// ----------------------------------------------------------------------------
module numeric_literal_parser_top
    import nlp_pkg::*;
#(
    parameter int WORD_BITS = 48,
    parameter int IN_DEPTH  = 4,
    parameter int OUT_DEPTH = 4
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 push,
    output logic                 full,
    input  logic [7:0]           i_ch,
    input  logic                 i_begin_req,
    input  logic                 i_at_end,
    output logic                 empty,
    input  logic                 pop,
    output logic [WORD_BITS-1:0] o_value,
    output logic [1:0]           o_error_code,
    output logic [1:0]           o_radix
);

    localparam int RES_W = WORD_BITS + 4;

    t_char_info           info;
    logic                 in_empty;
    logic                 in_pop;
    logic                 out_full;
    logic                 em_valid;
    logic [WORD_BITS-1:0] em_value;
    logic [1:0]           em_err;
    logic [1:0]           em_radix;
    logic [RES_W-1:0]     res_data;

    nlp_front #(
        .DEPTH (IN_DEPTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_full      (full),
        .i_ch        (i_ch),
        .i_begin_req (i_begin_req),
        .i_at_end    (i_at_end),
        .i_pop       (in_pop),
        .o_empty     (in_empty),
        .o_info      (info)
    );

    nlp_back #(
        .WORD_BITS (WORD_BITS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_empty (in_empty),
        .i_info     (info),
        .o_in_pop   (in_pop),
        .i_out_full (out_full),
        .o_em_valid (em_valid),
        .o_em_value (em_value),
        .o_em_err   (em_err),
        .o_em_radix (em_radix)
    );

    nlp_queue #(
        .WIDTH (RES_W),
        .DEPTH (OUT_DEPTH)
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (em_valid),
        .i_data  ({em_value, em_err, em_radix}),
        .o_full  (out_full),
        .i_pop   (pop),
        .o_data  (res_data),
        .o_empty (empty)
    );

    assign o_value      = res_data[RES_W-1:4];
    assign o_error_code = res_data[3:2];
    assign o_radix      = res_data[1:0];

endmodule

// File: rtl/core/nlp_checker.sv
// ----------------------------------------------------------------------------
// nlp_checker
// Port-level checks of the literal parser, bound to the top level.
// ----------------------------------------------------------------------------
module nlp_checker
    import nlp_pkg::*;
#(
    parameter int WORD_BITS = 48
) (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 push,
    input logic                 full,
    input logic                 empty,
    input logic                 pop,
    input logic [WORD_BITS-1:0] o_value,
    input logic [1:0]           o_error_code,
    input logic [1:0]           o_radix
);

    // reset leaves both sides open and nothing to deliver
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> empty && !full)
        else $error("queues not cleared by reset");

    // a failed literal never carries a value
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_error_code != ERR_NONE) |-> (o_value == '0))
        else $error("error result with nonzero value");

    // a waiting result holds until taken
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_value)
                              && $stable(o_error_code) && $stable(o_radix)))
        else $error("waiting result changed");

    // the input side fills only through accepted characters
    a_full_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(full) |-> $past(push))
        else $error("full rose without a push");

endmodule

bind numeric_literal_parser_top nlp_checker #(
    .WORD_BITS (WORD_BITS)
) u_nlp_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .push         (push),
    .full         (full),
    .empty        (empty),
    .pop          (pop),
    .o_value      (o_value),
    .o_error_code (o_error_code),
    .o_radix      (o_radix)
);
